@@ hdl/mchw_pkg.sv @@
// ============================================================================
// mchw_pkg
// Shared types and constants for the multi-client heartbeat watchdog.
// ============================================================================
`default_nettype none

package mchw_pkg;

    // Stream payload widths (fields packed low to high, zero padded to bytes)
    localparam int IN_TDATA_W  = 16;  // opcode[2:0], client_id[6:3], reload_value[14:7]
    localparam int OUT_TDATA_W = 24;  // assigned_id[3:0], table_full[4],
                                      // alert_mask[20:5], restart_request[21]

    // Field widths
    localparam int OP_W     = 3;
    localparam int ID_W     = 4;
    localparam int VAL_W    = 8;
    localparam int ALERT_W  = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_FAIL_LIMIT  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RELEASE_EXT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] FAIL_LIMIT_RST  = 8'd3;
    localparam logic [CFG_DATA_W-1:0] RELEASE_EXT_RST = 8'd2;

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER    = 3'd0,
        OP_KICK        = 3'd1,
        OP_TICK        = 3'd2,
        OP_SUSPEND     = 3'd3,
        OP_SUSPEND_ALL = 3'd4,
        OP_RELEASE     = 3'd5,
        OP_RELEASE_ALL = 3'd6
    } t_opcode;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;   // capture accepted transaction
        logic exec;   // run the execute-state part of the operation
        logic step;   // process one slot of a tick walk
        logic push;   // move result into output register
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic tick_walk;  // latched op is a tick with slots to walk and no global hold
        logic walk_last;  // current walk slot is the last registered one
    } t_dp_status;

endpackage

`default_nettype wire

@@ hdl/multi_client_heartbeat_watchdog_unit.sv @@
// ============================================================================
// multi_client_heartbeat_watchdog_unit
// Heartbeat watchdog for up to CLIENTS clients with per-client countdowns.
// ============================================================================
// Sequencing: accept, execute, then for a tick with registered clients and no
//   global hold the walk, then done, which pushes once the output is free.
// A new transaction is taken only after that push; the tick walk visits one
//   client slot per cycle through the single update path.
// Reset (synchronous, active low): table, suspend state and slot count clear,
//   fail_limit = 3, release_extension = 2, no result pending.
`default_nettype none

module multi_client_heartbeat_watchdog_unit #(
    parameter int CLIENTS = 16  // 1..32; ids and alert bits above 15 do not reach the ports
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    // Input stream
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // [2:0] opcode, [6:3] client_id, [14:7] reload_value, [15] zero
    input  wire logic [mchw_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,

    // Result stream
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // [3:0] assigned_id, [4] table_full, [20:5] alert_mask,
    // [21] restart_request, [23:22] zero
    output logic      [mchw_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,

    // Configuration write port: 0 fail_limit, 1 release_extension
    input  wire logic                                i_cfg_we,
    input  wire logic [mchw_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [mchw_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    mchw_pkg::t_dp_cmd    w_cmd;
    mchw_pkg::t_dp_status w_status;

    // Controller: owns the handshakes; input is taken only when idle, the
    // output register lets the next transaction start while a result waits.
    mchw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: client table, config registers, tick walk and result regs.
    mchw_dp #(
        .CLIENTS (CLIENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_s_axis_tdata),
        .o_out_data  (o_m_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

endmodule

`default_nettype wire

@@ hdl/mchw_dp.sv @@
// ============================================================================
// mchw_dp
// Watchdog datapath: client table, config registers, tick walk, result regs.
// ============================================================================
`default_nettype none

module mchw_dp #(
    parameter int CLIENTS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire mchw_pkg::t_dp_cmd                   i_cmd,
    output mchw_pkg::t_dp_status                     o_status,
    input  wire logic [mchw_pkg::IN_TDATA_W-1:0]     i_in_data,
    output logic      [mchw_pkg::OUT_TDATA_W-1:0]    o_out_data,
    input  wire logic                                i_cfg_we,
    input  wire logic [mchw_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [mchw_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int IW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int CW = $clog2(CLIENTS + 1);

    function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

    // latched transaction
    logic [mchw_pkg::OP_W-1:0]   r_op;
    logic [mchw_pkg::ID_W-1:0]   r_id;
    logic [mchw_pkg::VAL_W-1:0]  r_reload;

    // config
    logic [7:0] r_fail_limit;
    logic [7:0] r_rel_ext;

    // client table
    logic [7:0]         r_cd   [CLIENTS];
    logic [7:0]         r_miss [CLIENTS];
    logic [CLIENTS-1:0] r_susp;
    logic               r_all_susp;
    logic [CW-1:0]      r_count;

    // walk and results
    logic [IW-1:0]                  r_idx;
    logic [mchw_pkg::ID_W-1:0]      r_assigned;
    logic                           r_full;
    logic [mchw_pkg::ALERT_W-1:0]   r_alert;
    logic                           r_restart;
    logic [mchw_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic          w_reg_ok;
    logic [IW-1:0] w_new_slot;
    logic          w_new_held;
    logic          w_id_ok;
    logic [IW-1:0] w_id_slot;
    logic          w_id_held;
    logic [7:0]    w_reload_nz;
    logic [7:0]    w_cd;
    logic [7:0]    w_miss;
    logic [7:0]    w_miss_inc;
    logic          w_walk_held;
    logic [CW:0]   w_idx_next;

    assign w_reg_ok    = (r_count < CW'(CLIENTS));
    assign w_new_slot  = IW'(r_count);
    assign w_new_held  = r_all_susp || r_susp[w_new_slot];
    assign w_id_ok     = (32'(r_id) < CLIENTS);
    assign w_id_slot   = IW'(r_id);
    assign w_id_held   = r_all_susp || r_susp[w_id_slot];
    assign w_reload_nz = (r_reload == 8'd0) ? 8'd1 : r_reload;

    assign w_cd        = r_cd[r_idx];
    assign w_miss      = r_miss[r_idx];
    assign w_miss_inc  = (w_miss == 8'hFF) ? w_miss : w_miss + 8'd1;
    assign w_walk_held = r_susp[r_idx];
    assign w_idx_next  = (CW+1)'(r_idx) + (CW+1)'(1);

    assign o_status.tick_walk = (r_op == mchw_pkg::OP_TICK) && (r_count != '0) && !r_all_susp;
    assign o_status.walk_last = (w_idx_next == (CW+1)'(r_count));

    assign o_out_data = r_out_data;

    // table state and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CLIENTS; i++) begin
                r_cd[i]   <= '0;
                r_miss[i] <= '0;
            end
            r_susp       <= '0;
            r_all_susp   <= 1'b0;
            r_count      <= '0;
            r_fail_limit <= mchw_pkg::FAIL_LIMIT_RST;
            r_rel_ext    <= mchw_pkg::RELEASE_EXT_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    mchw_pkg::CFG_FAIL_LIMIT:  r_fail_limit <= i_cfg_wdata;
                    mchw_pkg::CFG_RELEASE_EXT: r_rel_ext    <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                case (r_op)
                    mchw_pkg::OP_REGISTER: begin
                        if (w_reg_ok) begin
                            if (!w_new_held) begin
                                r_cd[w_new_slot] <= w_reload_nz;
                            end
                            r_miss[w_new_slot] <= '0;
                            r_count            <= r_count + CW'(1);
                        end
                    end
                    mchw_pkg::OP_KICK: begin
                        if (w_id_ok && !w_id_held) begin
                            r_cd[w_id_slot] <= w_reload_nz;
                        end
                    end
                    mchw_pkg::OP_SUSPEND: begin
                        if (w_id_ok) begin
                            r_susp[w_id_slot] <= 1'b1;
                        end
                    end
                    mchw_pkg::OP_SUSPEND_ALL: begin
                        r_all_susp <= 1'b1;
                    end
                    mchw_pkg::OP_RELEASE: begin
                        if (w_id_ok) begin
                            r_cd[w_id_slot]   <= sat_add8(r_cd[w_id_slot], r_rel_ext);
                            r_susp[w_id_slot] <= 1'b0;
                        end
                    end
                    mchw_pkg::OP_RELEASE_ALL: begin
                        for (int i = 0; i < CLIENTS; i++) begin
                            if (CW'(i) < r_count) begin
                                r_cd[i] <= sat_add8(r_cd[i], r_rel_ext);
                            end
                        end
                        r_all_susp <= 1'b0;
                    end
                    default: ;  // tick work happens in the walk; unused code is a no-op
                endcase
            end
            if (i_cmd.step && !w_walk_held) begin
                if (w_cd == 8'd0) begin
                    r_miss[r_idx] <= w_miss_inc;
                end else begin
                    r_cd[r_idx]   <= w_cd - 8'd1;
                    r_miss[r_idx] <= '0;
                end
            end
        end
    end

    // transaction payload and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_in_data[2:0];
            r_id     <= i_in_data[6:3];
            r_reload <= i_in_data[14:7];
        end
        if (i_cmd.exec) begin
            r_idx      <= '0;
            r_alert    <= '0;
            r_restart  <= 1'b0;
            r_assigned <= '0;
            r_full     <= 1'b0;
            if (r_op == mchw_pkg::OP_REGISTER) begin
                if (w_reg_ok) begin
                    r_assigned <= mchw_pkg::ID_W'(w_new_slot);
                end else begin
                    r_full <= 1'b1;
                end
            end
        end
        if (i_cmd.step) begin
            r_idx <= r_idx + IW'(1);
            if (!w_walk_held && (w_cd == 8'd0)) begin
                r_alert <= r_alert | mchw_pkg::ALERT_W'(32'd1 << r_idx);
                if (w_miss_inc >= r_fail_limit) begin
                    r_restart <= 1'b1;
                end
            end
        end
        if (i_cmd.push) begin
            r_out_data <= {2'b00, r_restart, r_alert, r_full, r_assigned};
        end
    end

    // walk never goes past the registered slots
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> ((CW+1)'(r_idx) < (CW+1)'(r_count)))
        else $error("tick walk beyond registered clients");

    // a successful register grows the table by one
    a_reg_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_op == mchw_pkg::OP_REGISTER) && w_reg_ok)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("register did not advance slot count");

    // full flag only when every slot is taken
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_op == mchw_pkg::OP_REGISTER))
        |=> (r_full == ($past(r_count) == CW'(CLIENTS))))
        else $error("table_full disagrees with slot count");

endmodule

`default_nettype wire

@@ hdl/mchw_ctrl.sv @@
// ============================================================================
// mchw_ctrl
// Watchdog controller: sequences accept, execute, tick walk and result push.
// ============================================================================
`default_nettype none

module mchw_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire mchw_pkg::t_dp_status  i_status,
    output mchw_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_WALK = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.tick_walk ? ST_WALK : ST_DONE;
            end
            ST_WALK: begin
                o_cmd.step = 1'b1;
                if (i_status.walk_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // never overwrite an untaken result
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> (!r_out_valid || i_m_tready))
        else $error("result pushed over pending output");

    // accepted transaction goes straight to execute
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_EXEC))
        else $error("accept not followed by execute");

    // no walk unless the datapath asked for one
    a_no_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EXEC) && !i_status.tick_walk) |=> (r_state == ST_DONE))
        else $error("walk entered without a tick to run");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ============================================================================
// tb
// Self-checking bench for multi_client_heartbeat_watchdog_unit: streams
// watchdog commands in, mirrors the client table in a predictor and checks
// every returned verdict field by field under random stalls on both sides.
// ============================================================================
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Opcode 7 is unused by the block: it must answer with an all-zero verdict
    localparam logic [mchw_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int              NSLOTS    = 16;
    localparam int              HOLD_CYC  = 400;  // long receiver hold-off

    // Verdict layout, MSB first so it overlays o_m_axis_tdata directly
    typedef struct packed {
        logic [1:0]                   pad;
        logic                         restart;
        logic [mchw_pkg::ALERT_W-1:0] alerts;
        logic                         full;
        logic [mchw_pkg::ID_W-1:0]    assigned;
    } t_verdict;

    // ------------------------------------------------------------------------
    // Client table mirror plus queue of verdicts still owed by the block
    // ------------------------------------------------------------------------
    class t_heartbeat_tracker;
        logic [mchw_pkg::VAL_W-1:0] fail_limit;
        logic [mchw_pkg::VAL_W-1:0] release_ext;
        logic [mchw_pkg::VAL_W-1:0] countdown [NSLOTS];
        logic [mchw_pkg::VAL_W-1:0] misses    [NSLOTS];
        logic [NSLOTS-1:0]  held_mask;
        bit                 all_held;
        int                 enrolled;
        t_verdict           owed_q [$];
        int                 errors;
        int                 verdicts_seen;
        int                 n_cmds;
        int                 n_ticks;
        int                 n_alerted;
        int                 n_restarts;
        int                 n_full;

        function new();
            for (int i = 0; i < NSLOTS; i++) begin
                countdown[i] = '0;
                misses[i]    = '0;
            end
            held_mask   = '0;
            all_held    = 1'b0;
            enrolled    = 0;
            fail_limit  = mchw_pkg::FAIL_LIMIT_RST;
            release_ext = mchw_pkg::RELEASE_EXT_RST;
        endfunction

        function void set_config(logic [mchw_pkg::CFG_ADDR_W-1:0] addr,
                                 logic [mchw_pkg::CFG_DATA_W-1:0] data);
            if (addr == mchw_pkg::CFG_FAIL_LIMIT)
                fail_limit = data;
            else
                release_ext = data;
        endfunction

        function bit is_held(int slot);
            return all_held || held_mask[slot];
        endfunction

        function logic [mchw_pkg::VAL_W-1:0] sat_add(logic [mchw_pkg::VAL_W-1:0] a);
            int s;
            s = int'(a) + int'(release_ext);
            return (s > 255) ? 8'hFF : s[mchw_pkg::VAL_W-1:0];
        endfunction

        // Applies one accepted command and queues the verdict it owes
        function void note_command(logic [mchw_pkg::OP_W-1:0] op,
                                   logic [mchw_pkg::ID_W-1:0] id,
                                   logic [mchw_pkg::VAL_W-1:0] val);
            t_verdict                   v;
            logic [mchw_pkg::VAL_W-1:0] load;
            v    = '0;
            load = (val == 0) ? 8'd1 : val;
            n_cmds++;
            case (op)
                mchw_pkg::OP_REGISTER: begin
                    if (enrolled < NSLOTS) begin
                        if (!is_held(enrolled))
                            countdown[enrolled] = load;
                        misses[enrolled] = '0;
                        v.assigned = enrolled[mchw_pkg::ID_W-1:0];
                        enrolled++;
                    end else begin
                        v.full = 1'b1;
                        n_full++;
                    end
                end
                mchw_pkg::OP_KICK: begin
                    if (!is_held(id))
                        countdown[id] = load;
                end
                mchw_pkg::OP_TICK: begin
                    n_ticks++;
                    if (enrolled != 0 && !all_held) begin
                        for (int i = 0; i < enrolled; i++) begin
                            if (!is_held(i)) begin
                                if (countdown[i] == 0) begin
                                    v.alerts[i] = 1'b1;
                                    if (misses[i] != 8'hFF)
                                        misses[i]++;
                                    if (misses[i] >= fail_limit)
                                        v.restart = 1'b1;
                                end else begin
                                    countdown[i]--;
                                    misses[i] = '0;
                                end
                            end
                        end
                    end
                    if (v.alerts != 0)
                        n_alerted++;
                    if (v.restart)
                        n_restarts++;
                end
                mchw_pkg::OP_SUSPEND:     held_mask[id] = 1'b1;
                mchw_pkg::OP_SUSPEND_ALL: all_held = 1'b1;
                mchw_pkg::OP_RELEASE: begin
                    countdown[id] = sat_add(countdown[id]);
                    held_mask[id] = 1'b0;
                end
                mchw_pkg::OP_RELEASE_ALL: begin
                    for (int i = 0; i < enrolled; i++)
                        countdown[i] = sat_add(countdown[i]);
                    all_held = 1'b0;
                end
                default: ;
            endcase
            owed_q.push_back(v);
        endfunction

        function void check_verdict(logic [mchw_pkg::OUT_TDATA_W-1:0] data);
            t_verdict got;
            t_verdict want;
            got = data;
            verdicts_seen++;
            if (owed_q.size() == 0) begin
                $error("verdict 0x%06h arrived with nothing outstanding", data);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.assigned !== want.assigned) begin
                $error("assigned_id: expected %0d, got %0d", want.assigned, got.assigned);
                errors++;
            end
            if (got.full !== want.full) begin
                $error("table_full: expected %0b, got %0b", want.full, got.full);
                errors++;
            end
            if (got.alerts !== want.alerts) begin
                $error("alert_mask: expected 0x%04h, got 0x%04h", want.alerts, got.alerts);
                errors++;
            end
            if (got.restart !== want.restart) begin
                $error("restart_request: expected %0b, got %0b", want.restart, got.restart);
                errors++;
            end
            if (got.pad !== want.pad) begin
                $error("tdata padding: expected %0d, got %0d", want.pad, got.pad);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 s_tvalid    = 1'b0;
    logic                                 s_tready;
    logic [mchw_pkg::IN_TDATA_W-1:0]      s_tdata     = '0;
    logic                                 m_tvalid;
    logic                                 m_tready    = 1'b0;
    logic [mchw_pkg::OUT_TDATA_W-1:0]     m_tdata;
    logic                                 cfg_we      = 1'b0;
    logic [mchw_pkg::CFG_ADDR_W-1:0]      cfg_addr    = '0;
    logic [mchw_pkg::CFG_DATA_W-1:0]      cfg_wdata   = '0;

    bit                                   hold_done   = 1'b0;

    t_heartbeat_tracker                   tracker = new();

    multi_client_heartbeat_watchdog_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Idle gap: mostly none, sometimes a few cycles, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Reload values lean small so countdowns actually run out
    function automatic logic [mchw_pkg::VAL_W-1:0] pick_reload();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return mchw_pkg::VAL_W'($urandom_range(0, 4));
        if (r == 5)
            return 8'hFF;
        return mchw_pkg::VAL_W'($urandom_range(0, 255));
    endfunction

    // Offers one command, holds it until the transaction completes, then
    // updates the predictor. tvalid stays high into the next call when that
    // call has no gap, so it is never dropped and raised in one step.
    task automatic send_cmd(input logic [mchw_pkg::OP_W-1:0] op,
                            input logic [mchw_pkg::ID_W-1:0] id,
                            input logic [mchw_pkg::VAL_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, val, id, op};
        do @(posedge i_clk); while (!s_tready);
        tracker.note_command(op, id, val);
    endtask

    // Register writes only with the block drained and quiet
    task automatic write_cfg(input logic [mchw_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [mchw_pkg::CFG_DATA_W-1:0] data);
        s_tvalid <= 1'b0;
        while (tracker.owed_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        tracker.set_config(addr, data);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Mixed traffic; ids mostly target enrolled clients
    task automatic send_random(input int count);
        int                        r;
        logic [mchw_pkg::OP_W-1:0] op;
        logic [mchw_pkg::ID_W-1:0] id;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 8)       op = mchw_pkg::OP_REGISTER;
            else if (r < 38) op = mchw_pkg::OP_KICK;
            else if (r < 66) op = mchw_pkg::OP_TICK;
            else if (r < 74) op = mchw_pkg::OP_SUSPEND;
            else if (r < 77) op = mchw_pkg::OP_SUSPEND_ALL;
            else if (r < 88) op = mchw_pkg::OP_RELEASE;
            else if (r < 94) op = mchw_pkg::OP_RELEASE_ALL;
            else if (r < 97) op = OP_UNUSED;
            else             op = mchw_pkg::OP_KICK;
            if (tracker.enrolled > 0 && $urandom_range(0, 9) < 7)
                id = mchw_pkg::ID_W'($urandom_range(0, tracker.enrolled - 1));
            else
                id = mchw_pkg::ID_W'($urandom_range(0, NSLOTS - 1));
            send_cmd(op, id, pick_reload());
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: check every completed transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            tracker.check_verdict(m_tdata);
    end

    // Receiver: random ready runs and stalls, plus one long hold-off once
    // traffic is flowing so the block backs up and stalls its input.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (!hold_done && tracker.verdicts_seen >= 250) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYC) @(posedge i_clk);
                hold_done = 1'b1;
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Watchdog on the bench itself
    initial begin
        #8ms;
        $display("multi_client_heartbeat_watchdog_unit verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset config (fail_limit 3, release_extension 2)
        send_cmd(mchw_pkg::OP_TICK, 4'd0, 8'd0);          // empty table: no effect
        send_cmd(mchw_pkg::OP_KICK, 4'd5, 8'd0);          // unenrolled slot still loads
        send_cmd(mchw_pkg::OP_RELEASE, 4'd9, 8'd0);       // unenrolled slot still extends
        send_cmd(OP_UNUSED, 4'd15, 8'hFF);                // unused opcode, all ones
        send_cmd(mchw_pkg::OP_REGISTER, 4'd0, 8'd0);      // slot 0, zero reload -> 1
        send_cmd(mchw_pkg::OP_REGISTER, 4'd0, 8'hFF);     // slot 1
        send_cmd(mchw_pkg::OP_SUSPEND, 4'd2, 8'd0);
        send_cmd(mchw_pkg::OP_REGISTER, 4'd0, 8'd7);      // slot 2 held: misses clear only
        send_cmd(mchw_pkg::OP_TICK, 4'd0, 8'd0);
        send_cmd(mchw_pkg::OP_TICK, 4'd0, 8'd0);          // slot 0 alerts from here on
        send_cmd(mchw_pkg::OP_TICK, 4'd0, 8'd0);
        send_cmd(mchw_pkg::OP_TICK, 4'd0, 8'd0);          // third miss: restart
        send_cmd(mchw_pkg::OP_KICK, 4'd2, 8'd9);          // held client ignores kick
        send_cmd(mchw_pkg::OP_SUSPEND_ALL, 4'd0, 8'd0);
        send_cmd(mchw_pkg::OP_REGISTER, 4'd0, 8'd4);      // slot 3 under global hold
        send_cmd(mchw_pkg::OP_TICK, 4'd0, 8'd0);          // global hold: nothing moves
        send_cmd(mchw_pkg::OP_KICK, 4'd0, 8'd3);          // ignored under global hold
        send_cmd(mchw_pkg::OP_RELEASE_ALL, 4'd0, 8'd0);
        send_cmd(mchw_pkg::OP_RELEASE, 4'd2, 8'd0);
        send_cmd(mchw_pkg::OP_TICK, 4'd0, 8'd0);

        // Zero fail limit and full extension: saturating release, any miss
        // requests a restart
        write_cfg(mchw_pkg::CFG_FAIL_LIMIT, 8'd0);
        write_cfg(mchw_pkg::CFG_RELEASE_EXT, 8'hFF);
        send_cmd(mchw_pkg::OP_RELEASE, 4'd1, 8'd0);
        send_cmd(mchw_pkg::OP_TICK, 4'd0, 8'd0);
        send_cmd(mchw_pkg::OP_TICK, 4'd0, 8'd0);
        send_cmd(mchw_pkg::OP_TICK, 4'd0, 8'd0);

        // Random phases across several settings
        write_cfg(mchw_pkg::CFG_FAIL_LIMIT, 8'd1);
        write_cfg(mchw_pkg::CFG_RELEASE_EXT, 8'd0);
        send_random(110);

        write_cfg(mchw_pkg::CFG_FAIL_LIMIT, 8'hFF);
        write_cfg(mchw_pkg::CFG_RELEASE_EXT, 8'hFF);
        send_random(110);

        write_cfg(mchw_pkg::CFG_FAIL_LIMIT, mchw_pkg::CFG_DATA_W'($urandom_range(1, 255)));
        write_cfg(mchw_pkg::CFG_RELEASE_EXT, mchw_pkg::CFG_DATA_W'($urandom_range(0, 255)));
        send_random(110);

        // Miss counter saturation: slot 0 left to miss for more than 255
        // ticks; with the limit at 255 a wrapping counter would stop the
        // restart requests.
        write_cfg(mchw_pkg::CFG_FAIL_LIMIT, 8'hFF);
        write_cfg(mchw_pkg::CFG_RELEASE_EXT, 8'd0);
        send_cmd(mchw_pkg::OP_RELEASE_ALL, 4'd0, 8'd0);
        for (int i = 0; i < NSLOTS; i++)
            send_cmd(mchw_pkg::OP_RELEASE, i[mchw_pkg::ID_W-1:0], 8'd0);
        send_cmd(mchw_pkg::OP_KICK, 4'd0, 8'd1);
        repeat (265) begin
            send_cmd(mchw_pkg::OP_TICK, 4'd0, 8'd0);
            if ($urandom_range(0, 9) < 3)
                send_cmd(mchw_pkg::OP_KICK,
                         mchw_pkg::ID_W'($urandom_range(1, NSLOTS - 1)), pick_reload());
        end

        // Back to reset values
        write_cfg(mchw_pkg::CFG_FAIL_LIMIT, mchw_pkg::FAIL_LIMIT_RST);
        write_cfg(mchw_pkg::CFG_RELEASE_EXT, mchw_pkg::RELEASE_EXT_RST);
        send_random(150);

        // Drain, then allow for a full tick walk of stray output
        s_tvalid <= 1'b0;
        while (tracker.owed_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Ran %0d commands incl. %0d ticks: %0d with alerts, %0d restart requests,",
                 tracker.n_cmds, tracker.n_ticks, tracker.n_alerted, tracker.n_restarts);
        $display("%0d full-table answers, %0d verdicts checked, %0d mismatches",
                 tracker.n_full, tracker.verdicts_seen, tracker.errors);
        if (tracker.errors == 0)
            $display("multi_client_heartbeat_watchdog_unit verification clean");
        else
            $display("multi_client_heartbeat_watchdog_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
